// ===== sv/fla_pkg.sv =====
package fla_pkg;

   localparam int SLOTS   = 256;
   localparam int SLOT_W  = 8;
   localparam int COUNT_W = 9;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SLOT  = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_code_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_LOOKUP
   } state_type;

   typedef struct packed {
      logic accept;
      logic lookup_done;
   } cmd_type;

   typedef struct packed {
      logic alloc_pop;
      logic rsp_busy;
   } dp_flags_type;

endpackage

// ===== sv/fla_req_if.sv =====
interface fla_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [fla_pkg::SLOT_W-1:0] slot_index;

   modport source (output valid, output kind, output slot_index, input ready);
   modport sink (input valid, input kind, input slot_index, output ready);
endinterface

// ===== sv/fla_rsp_if.sv =====
interface fla_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fla_pkg::SLOT_W-1:0]  granted_slot;
   logic [1:0]                  status;
   logic [fla_pkg::COUNT_W-1:0] used_count;

   modport source (output valid, output granted_slot, output status, output used_count,
                   input ready);
   modport sink (input valid, input granted_slot, input status, input used_count,
                 output ready);
endinterface

// ===== sv/fla_ram.sv =====
module fla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fla_controller.sv =====
module fla_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fla_pkg::dp_flags_type flags,
   output fla_pkg::cmd_type      cmd
);
   import fla_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            req_ready = !flags.rsp_busy;
            if (req_valid && !flags.rsp_busy) begin
               cmd.accept = 1'b1;
               if (flags.alloc_pop) begin
                  state_in = STATE_LOOKUP;
               end
            end
         end
         STATE_LOOKUP: begin
            cmd.lookup_done = 1'b1;
            state_in        = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/fla_datapath.sv =====
module fla_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  fla_pkg::cmd_type             cmd,
   output fla_pkg::dp_flags_type        flags,
   input  logic                         kind,
   input  logic [fla_pkg::SLOT_W-1:0]   slot_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fla_pkg::SLOT_W-1:0]   granted_slot,
   output logic [1:0]                   status,
   output logic [fla_pkg::COUNT_W-1:0]  used_count
);
   import fla_pkg::*;

   logic [SLOT_W-1:0]  head_ff;
   logic [SLOT_W-1:0]  head_in;
   logic [COUNT_W-1:0] in_use_ff;
   logic [COUNT_W-1:0] in_use_in;
   logic [SLOTS-1:0]   link_valid_ff;
   logic               lookup_valid_ff;
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  granted_ff;
   logic [SLOT_W-1:0]  granted_in;
   status_code_type    status_ff;
   status_code_type    status_in;
   logic [COUNT_W-1:0] used_ff;
   logic [SLOT_W-1:0]  link_rd_data;
   logic [SLOT_W-1:0]  head_succ;
   logic               alloc_pop;
   logic               free_push;
   logic               link_wr_en;

   assign alloc_pop  = (kind == KIND_ALLOC) && (in_use_ff != COUNT_W'(SLOTS));
   assign free_push  = (kind == KIND_FREE) && (in_use_ff != '0)
                       && ({1'b0, slot_index} < COUNT_W'(SLOTS));
   assign link_wr_en = cmd.accept && free_push;
   assign head_succ  = (head_ff == SLOT_W'(SLOTS - 1)) ? '0 : head_ff + 1'b1;

   fla_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(SLOTS)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (link_wr_en),
      .wr_addr(slot_index),
      .wr_data(head_ff),
      .rd_addr(head_ff),
      .rd_data(link_rd_data)
   );

   always_comb begin
      head_in    = head_ff;
      in_use_in  = in_use_ff;
      granted_in = '0;
      status_in  = STATUS_OK;
      if (cmd.lookup_done) begin
         head_in = lookup_valid_ff ? link_rd_data : head_succ;
      end
      if (cmd.accept) begin
         if (kind == KIND_ALLOC) begin
            if (alloc_pop) begin
               granted_in = head_ff;
               in_use_in  = in_use_ff + 1'b1;
            end else begin
               status_in = STATUS_NO_SLOT;
            end
         end else begin
            if (free_push) begin
               head_in   = slot_index;
               in_use_in = in_use_ff - 1'b1;
            end else begin
               status_in = STATUS_BAD_FREE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         in_use_ff     <= '0;
         link_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff   <= head_in;
         in_use_ff <= in_use_in;
         if (link_wr_en) begin
            link_valid_ff[slot_index] <= 1'b1;
         end
         if (cmd.accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lookup_valid_ff <= link_valid_ff[head_ff];
      if (cmd.accept) begin
         granted_ff <= granted_in;
         status_ff  <= status_in;
         used_ff    <= in_use_in;
      end
   end

   assign flags.alloc_pop = alloc_pop;
   assign flags.rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign granted_slot    = granted_ff;
   assign status          = status_ff;
   assign used_count      = used_ff;

endmodule

// ===== sv/free_list_slot_allocator_unit.sv =====
// Each request gives one response beat, registered and valid the cycle after acceptance.
// A free or any rejected request occupies the unit in the idle state alone; a successful
// allocate adds the lookup state, as the head's link comes from the registered RAM read.
// A new request is taken only when the response register is empty or its beat leaves then.
// Reset is synchronous and active high; per-entry valid flags make the link RAM read as its
// initial chain at once, so no clearing pass follows reset.
module free_list_slot_allocator_unit (
   input logic      clock,
   input logic      reset,
   fla_req_if.sink  req_bus,
   fla_rsp_if.source rsp_bus
);
   import fla_pkg::*;

   cmd_type      cmd;
   dp_flags_type flags;

   fla_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .flags    (flags),
      .cmd      (cmd)
   );

   fla_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .flags       (flags),
      .kind        (req_bus.kind),
      .slot_index  (req_bus.slot_index),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .granted_slot(rsp_bus.granted_slot),
      .status      (rsp_bus.status),
      .used_count  (rsp_bus.used_count)
   );

endmodule

// ===== sv/fla_checker.sv =====
module fla_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [fla_pkg::SLOT_W-1:0]  granted_slot,
   input logic [1:0]                  status,
   input logic [fla_pkg::COUNT_W-1:0] used_count
);
   import fla_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response beat dropped before it was taken.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted request did not produce a response beat.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("Request accepted while a pending response beat would be overwritten.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STATUS_OK |-> granted_slot == '0)
      else $error("Rejected request returned a nonzero slot.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> used_count <= COUNT_W'(SLOTS))
      else $error("Used count exceeds the pool size.");

endmodule

bind free_list_slot_allocator_unit fla_checker u_fla_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .granted_slot(rsp_bus.granted_slot),
   .status      (rsp_bus.status),
   .used_count  (rsp_bus.used_count)
);

// ===== tb/tb_free_list_slot_allocator_unit.sv =====
`timescale 1ns / 100ps

module tb_free_list_slot_allocator_unit;
   import fla_pkg::*;

   typedef struct {
      logic [SLOT_W-1:0]  granted_slot;
      status_code_type    status;
      logic [COUNT_W-1:0] used_count;
   } slot_reply_type;

   class slot_pool_tracker;
      logic [SLOT_W-1:0]  link_ram [SLOTS];
      logic [SLOT_W-1:0]  head;
      logic [COUNT_W-1:0] in_use;
      slot_reply_type     pending_replies[$];
      logic [SLOT_W-1:0]  held_slots[$];
      int                 failures;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            link_ram[i] = SLOT_W'(i + 1);
         end
         head = '0;
         in_use = '0;
         failures = 0;
      endfunction

      function void record_request(logic kind, logic [SLOT_W-1:0] idx);
         slot_reply_type reply;
         reply.granted_slot = '0;
         reply.status = STATUS_OK;
         if (kind == KIND_ALLOC) begin
            if (in_use >= SLOTS) begin
               reply.status = STATUS_NO_SLOT;
            end else begin
               reply.granted_slot = head;
               head = link_ram[head];
               in_use++;
               held_slots.push_back(reply.granted_slot);
            end
         end else if (in_use == 0 || idx >= SLOTS) begin
            reply.status = STATUS_BAD_FREE;
         end else begin
            link_ram[idx] = head;
            head = idx;
            in_use--;
            for (int i = 0; i < held_slots.size(); i++) begin
               if (held_slots[i] == idx) begin
                  held_slots.delete(i);
                  break;
               end
            end
         end
         reply.used_count = in_use;
         pending_replies.push_back(reply);
      endfunction

      function void check_response(logic [SLOT_W-1:0] granted, logic [1:0] status,
                                   logic [COUNT_W-1:0] used);
         slot_reply_type want;
         if (pending_replies.size() == 0) begin
            $error("response beat with no request outstanding: %s %0d %s %0d %s %0d",
                   "granted_slot", granted, "status", status, "used_count", used);
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         if (granted !== want.granted_slot) begin
            $error("granted_slot: expected %0d, actual %0d", want.granted_slot, granted);
            failures++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (used !== want.used_count) begin
            $error("used_count: expected %0d, actual %0d", want.used_count, used);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending_replies.size();
      endfunction

      function logic [SLOT_W-1:0] pick_held();
         return held_slots[$urandom_range(held_slots.size() - 1)];
      endfunction
   endclass

   logic clock;
   logic reset;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   int   hold_ready_cycles;
   int   random_issued;

   slot_pool_tracker tracker;

   fla_req_if req_bus ();
   fla_rsp_if rsp_bus ();

   free_list_slot_allocator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         tracker.record_request(req_bus.kind, req_bus.slot_index);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_response(rsp_bus.granted_slot, rsp_bus.status, rsp_bus.used_count);
      end
   end

   // The long hold-off is counted here so that the sender keeps offering beats meanwhile.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ready_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_ready_cycles) @(posedge clock);
            hold_ready_cycles = 0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   task automatic set_idling(int phase);
      case (phase)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
         default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
      endcase
   endtask

   task automatic send_request(logic kind, logic [SLOT_W-1:0] idx);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.slot_index <= idx;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   task automatic wait_for_replies();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic issue_mix(int count, int alloc_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < alloc_pct) begin
            send_request(KIND_ALLOC, SLOT_W'($urandom));
         end else if (tracker.held_slots.size() != 0 && $urandom_range(99) >= 8) begin
            send_request(KIND_FREE, tracker.pick_held());
         end else begin
            send_request(KIND_FREE, SLOT_W'($urandom));
         end
         random_issued++;
      end
   endtask

   initial begin
      int wave;
      int bias;
      tracker = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_ALLOC;
      req_bus.slot_index = '0;
      rsp_bus.ready = 1'b0;
      hold_ready_cycles = 0;
      random_issued = 0;
      set_idling(0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(KIND_FREE, 8'h00);
      send_request(KIND_ALLOC, 8'hFF);
      send_request(KIND_ALLOC, 8'h00);
      send_request(KIND_ALLOC, 8'h00);
      send_request(KIND_FREE, 8'h01);
      send_request(KIND_ALLOC, 8'h00);
      send_request(KIND_ALLOC, 8'h00);
      // Slot 255 was never handed out, so this free goes undetected and corrupts the list.
      send_request(KIND_FREE, 8'hFF);
      send_request(KIND_ALLOC, 8'h00);
      send_request(KIND_ALLOC, 8'h00);
      send_request(KIND_FREE, 8'hAA);
      send_request(KIND_FREE, 8'h55);
      send_request(KIND_FREE, 8'h00);
      send_request(KIND_FREE, 8'h02);
      send_request(KIND_FREE, 8'h03);
      send_request(KIND_FREE, 8'h01);
      send_request(KIND_FREE, 8'hFF);
      send_request(KIND_FREE, 8'h04);
      send_request(KIND_ALLOC, 8'hAA);
      send_request(KIND_ALLOC, 8'h55);
      wait_for_replies();

      hold_ready_cycles = 200;
      issue_mix(30, 60);
      wait_for_replies();

      random_issued = 0;
      issue_mix(320, 96);
      wait_for_replies();
      wave = 0;
      while (random_issued < 1250) begin
         set_idling(wave % 4);
         case ($urandom_range(4))
            0: bias = 90;
            1: bias = 65;
            2: bias = 50;
            3: bias = 35;
            default: bias = 10;
         endcase
         issue_mix($urandom_range(60, 200), bias);
         wave++;
      end
      set_idling(3);
      issue_mix(330, 4);

      set_idling(0);
      wait_for_replies();
      repeat (10) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
